>>> hw/rtl/biorthogonal_code_codec_unit_macros.svh
// Assertion macros used by the codec top-level RTL file.
`ifndef BIORTHOGONAL_CODE_CODEC_UNIT_MACROS_SVH
`define BIORTHOGONAL_CODE_CODEC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BOCC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bocc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BOCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bocc: next-cycle check failed");

`endif

>>> hw/rtl/bocc_pkg.sv
// Package: code sizes, port and candidate types, codebook and minimum-pick functions of the codec.
`default_nettype none
package bocc_pkg;

	localparam int MSG_BITS  = 4;
	localparam int NBITS     = 1 << (MSG_BITS - 1);
	localparam int DIST_W    = $clog2(NBITS + 1);
	localparam int TREE_LVLS = MSG_BITS - 1;
	localparam int S2_LVLS   = TREE_LVLS / 2;
	localparam int S2_CNT    = NBITS >> S2_LVLS;
	localparam int MSG_W     = 4;
	localparam int CW_W      = 8;

	typedef logic [NBITS-1:0]    code_t;
	typedef logic [MSG_BITS-2:0] row_t;
	typedef logic [MSG_BITS-1:0] idx_t;
	typedef logic [DIST_W-1:0]   dist_t;
	typedef logic [MSG_W-1:0]    msg_port_t;
	typedef logic [CW_W-1:0]     cw_port_t;

	typedef enum logic {
		FUNC_ENCODE = 1'b0,
		FUNC_DECODE = 1'b1
	} func_t;

	typedef struct packed {
		dist_t hd;
		idx_t  idx;
	} cand_t;

	// Codeword of a row in the top half: column c is set on even parity of row & c.
	function automatic code_t row_code(input row_t row);
		code_t w;
		row_t  col;
		w = '0;
		for (int c = 0; c < NBITS; c++) begin
			col = row_t'(c);
			w[NBITS-1-c] = ~(^(row & col));
		end
		return w;
	endfunction

	// Full codebook entry: the bottom half is the complement of its top-half row.
	function automatic code_t enc_code(input idx_t m);
		code_t w;
		w = row_code(m[MSG_BITS-2:0]);
		if (m[MSG_BITS-1]) begin
			w = ~w;
		end
		return w;
	endfunction

	// Smaller distance wins; on a tie the lower codeword index wins.
	function automatic cand_t pick_min(input cand_t a, input cand_t b);
		cand_t r;
		r = a;
		if ((b.hd < a.hd) || ((b.hd == a.hd) && (b.idx < a.idx))) begin
			r = b;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bocc_corr.sv
// Hamming distance of the received word to every top-half codebook row.
`default_nettype none
module bocc_corr (
	input  bocc_pkg::code_t rx,
	output bocc_pkg::dist_t row_hd [bocc_pkg::NBITS]
);
	import bocc_pkg::*;

	always_comb begin
		for (int r = 0; r < NBITS; r++) begin
			row_hd[r] = dist_t'($countones(rx ^ row_code(row_t'(r))));
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/biorthogonal_code_codec_unit.sv
// Top level: pipelined biorthogonal (first-order Reed-Muller) encoder and decoder.
//
// Input channel: in_valid / in_stall carry func, message_in and received_word.
// A beat moves on a rising edge with in_valid high and in_stall low.
// func encode maps message_in to its codeword; func decode returns the index
// of the nearest codeword (first one at minimum Hamming distance).
// Output channel: out_valid / out_stall carry codeword_out and message_out;
// the field not used by the operation reads zero.
// Pipeline: stage 1 holds the distances to the top-half rows (and the encoded
// word), stage 2 the per-row pick against the complement plus the first level
// of the minimum tree, stage 3 the rest of the tree and is the output register.
// Throughput: one beat per cycle, set by the three-stage pipeline advancing
// every cycle while the receiver takes results.
// Stall: each stage holds while the one after it is full and held, so a
// bubble is squeezed out; in_stall rises only when all three stages are full
// and out_stall is high. Nothing is lost or repeated.
// Reset: arst_n clears the stage valid bits; the data registers are not reset.
`default_nettype none
`include "biorthogonal_code_codec_unit_macros.svh"
module biorthogonal_code_codec_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [bocc_pkg::MSG_W-1:0]   message_in,
	input  logic [bocc_pkg::CW_W-1:0]    received_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bocc_pkg::CW_W-1:0]    codeword_out,
	output logic [bocc_pkg::MSG_W-1:0]   message_out
);
	import bocc_pkg::*;

	// Stage enables: advance a stage when it is empty or its successor moves.
	logic en1, en2, en3;

	logic  v_s1, v_s2, v_s3;
	func_t func_s1, func_s2;
	code_t cw_s1, cw_s2;
	dist_t dist_s1 [NBITS];
	cand_t cand_s2 [S2_CNT];
	cw_port_t  cw_s3;
	msg_port_t msg_s3;

	code_t rx;
	dist_t dist_c [NBITS];
	cand_t tree2 [NBITS];
	cand_t tree3 [S2_CNT];

	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	// Drop received bits above the code length.
	assign rx = code_t'(received_word);

	bocc_corr u_corr (
		.rx     (rx),
		.row_hd (dist_c)
	);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 1: distances to the top-half rows, encoded word.
	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1 <= func_t'(func);
			cw_s1   <= enc_code(idx_t'(message_in));
			dist_s1 <= dist_c;
		end
	end

	// Stage 2: each row against its complement (distance NBITS - d), then
	// the first levels of the minimum tree.
	always_comb begin
		for (int i = 0; i < NBITS; i++) begin
			tree2[i].hd  = dist_s1[i];
			tree2[i].idx = idx_t'(i);
			if ((dist_t'(NBITS) - dist_s1[i]) < dist_s1[i]) begin
				tree2[i].hd  = dist_t'(NBITS) - dist_s1[i];
				tree2[i].idx = {1'b1, row_t'(i)};
			end
		end
		for (int lv = 0; lv < S2_LVLS; lv++) begin
			for (int i = 0; i < (NBITS >> (lv + 1)); i++) begin
				tree2[i] = pick_min(tree2[2*i], tree2[2*i+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			func_s2 <= func_s1;
			cw_s2   <= cw_s1;
			for (int i = 0; i < S2_CNT; i++) begin
				cand_s2[i] <= tree2[i];
			end
		end
	end

	// Stage 3: rest of the tree, then zero the field the operation does not use.
	always_comb begin
		for (int i = 0; i < S2_CNT; i++) begin
			tree3[i] = cand_s2[i];
		end
		for (int lv = 0; lv < TREE_LVLS - S2_LVLS; lv++) begin
			for (int i = 0; i < (S2_CNT >> (lv + 1)); i++) begin
				tree3[i] = pick_min(tree3[2*i], tree3[2*i+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			if (func_s2 == FUNC_DECODE) begin
				cw_s3  <= '0;
				msg_s3 <= msg_port_t'(tree3[0].idx);
			end else begin
				cw_s3  <= cw_port_t'(cw_s2);
				msg_s3 <= '0;
			end
		end
	end

	assign out_valid    = v_s3;
	assign codeword_out = cw_s3;
	assign message_out  = msg_s3;

	`BOCC_ASSERT_IMPL(a_stall_only_full, in_stall, v_s1 && v_s2 && v_s3 && out_stall)
	`BOCC_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, v_s1)
	`BOCC_ASSERT_NEXT(a_s2_moves_out, v_s2 && en3, out_valid)
	`BOCC_ASSERT_IMPL(a_one_field_used, out_valid, codeword_out == '0 || message_out == '0)

endmodule
`default_nettype wire

>>> test/tb_biorthogonal_code_codec_unit.sv
// Testbench, biorthogonal codec unit: directed and random beats vs known results or a codebook model.
module tb_biorthogonal_code_codec_unit;
	import bocc_pkg::*;

	localparam int N_DIRECTED     = 20;
	localparam int RAND_BEATS     = 1400;
	localparam int CALM_TAIL      = 150;
	localparam int LONG_HOLD      = 48;
	localparam int HOLD_AFTER     = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;

	typedef struct {
		cw_port_t  cw;
		msg_port_t msg;
	} codec_result_t;

	// One directed beat; typed rows carry their known result, the rest go to the model.
	typedef struct {
		func_t     op;
		msg_port_t msg;
		cw_port_t  rx;
		bit        typed;
		cw_port_t  cw;
		msg_port_t idx;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                func;
	logic [MSG_W-1:0]    message_in;
	logic [CW_W-1:0]     received_word;
	logic                out_valid;
	logic                out_stall;
	logic [CW_W-1:0]     codeword_out;
	logic [MSG_W-1:0]    message_out;

	// Known result that travels alongside the presented beat.
	bit                  cur_typed;
	codec_result_t       cur_typed_result;

	codec_result_t       pending_results[$];
	int                  errors       = 0;
	int                  beats_in     = 0;
	int                  quiet_cycles = 0;
	bit                  calm         = 1'b0;
	bit                  holding      = 1'b0;
	bit                  held_long    = 1'b0;

	// Extremes, both operations, ignored-field noise, single-bit errors and ties.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{FUNC_ENCODE, 4'h0, 8'h00, 1'b1, 8'hFF, 4'h0},
		'{FUNC_ENCODE, 4'h8, 8'hFF, 1'b1, 8'h00, 4'h0},
		'{FUNC_ENCODE, 4'h1, 8'h00, 1'b1, 8'hAA, 4'h0},
		'{FUNC_ENCODE, 4'h9, 8'h5A, 1'b1, 8'h55, 4'h0},
		'{FUNC_ENCODE, 4'h7, 8'h00, 1'b0, 8'h00, 4'h0},
		'{FUNC_ENCODE, 4'hF, 8'hA5, 1'b0, 8'h00, 4'h0},
		'{FUNC_ENCODE, 4'h4, 8'h00, 1'b0, 8'h00, 4'h0},
		'{FUNC_ENCODE, 4'hE, 8'h00, 1'b0, 8'h00, 4'h0},
		'{FUNC_ENCODE, 4'h2, 8'h81, 1'b0, 8'h00, 4'h0},
		'{FUNC_DECODE, 4'h0, 8'hFF, 1'b1, 8'h00, 4'h0},
		'{FUNC_DECODE, 4'hF, 8'h00, 1'b1, 8'h00, 4'h8},
		'{FUNC_DECODE, 4'h0, 8'hAA, 1'b1, 8'h00, 4'h1},
		'{FUNC_DECODE, 4'h0, 8'h55, 1'b1, 8'h00, 4'h9},
		'{FUNC_DECODE, 4'h0, 8'h69, 1'b0, 8'h00, 4'h0},
		'{FUNC_DECODE, 4'h0, 8'hFE, 1'b0, 8'h00, 4'h0},
		'{FUNC_DECODE, 4'h0, 8'h80, 1'b0, 8'h00, 4'h0},
		'{FUNC_DECODE, 4'h0, 8'hFC, 1'b0, 8'h00, 4'h0},
		'{FUNC_DECODE, 4'h0, 8'h0F, 1'b0, 8'h00, 4'h0},
		'{FUNC_DECODE, 4'hA, 8'h3C, 1'b0, 8'h00, 4'h0},
		'{FUNC_DECODE, 4'h5, 8'hC3, 1'b0, 8'h00, 4'h0}
	};

	biorthogonal_code_codec_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.message_in    (message_in),
		.received_word (received_word),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.codeword_out  (codeword_out),
		.message_out   (message_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Codebook entry of index m: top half by column parity, bottom half complemented.
	function automatic code_t codebook_word(input int unsigned m);
		code_t       w;
		int unsigned row;
		row = m % NBITS;
		w   = '0;
		for (int c = 0; c < NBITS; c++) begin
			if ($countones(row & c) % 2 == 0) begin
				w[NBITS-1-c] = 1'b1;
			end
		end
		if ((m / NBITS) % 2 == 1) begin
			w = ~w;
		end
		return w;
	endfunction

	// Result of one beat; the unused field reads zero.
	function automatic codec_result_t codec_outcome(input func_t op, input msg_port_t m,
			input cw_port_t rx);
		codec_result_t r;
		code_t         word;
		int            best;
		int            d;
		r.cw  = '0;
		r.msg = '0;
		if (op == FUNC_ENCODE) begin
			r.cw = cw_port_t'(codebook_word(m));
		end else begin
			// received bits above the code drop off in this cast
			word = code_t'(rx);
			best = NBITS + 1;
			// strict compare keeps the lowest index on a tie
			for (int j = 0; j < 2 * NBITS; j++) begin
				d = $countones(word ^ codebook_word(j));
				if (d < best) begin
					best  = d;
					r.msg = msg_port_t'(j);
				end
			end
		end
		return r;
	endfunction

	// Present one beat and hold it until the block takes it.
	task automatic send_beat(input func_t op, input msg_port_t m, input cw_port_t rx,
			input bit typed, input codec_result_t typed_res);
		in_valid         <= 1'b1;
		func             <= op;
		message_in       <= m;
		received_word    <= rx;
		cur_typed        <= typed;
		cur_typed_result <= typed_res;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid for a random burst, except in the calm tail or while the receiver holds off.
	task automatic sender_pause();
		if (!calm && !holding && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		stim_row_t     r;
		codec_result_t typed_res;
		codec_result_t no_result;
		func_t         op;
		msg_port_t     m;
		cw_port_t      rx;
		int            pick;

		no_result.cw     = '0;
		no_result.msg    = '0;
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		func             <= FUNC_ENCODE;
		message_in       <= '0;
		received_word    <= '0;
		cur_typed        <= 1'b0;
		cur_typed_result <= no_result;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows.
		for (int i = 0; i < N_DIRECTED; i++) begin
			r             = directed_rows[i];
			typed_res.cw  = r.cw;
			typed_res.msg = r.idx;
			send_beat(r.op, r.msg, r.rx, r.typed, typed_res);
			sender_pause();
		end

		// Random beats: encodes, and decodes of codewords with up to three flipped bits or of raw noise words.
		for (int i = 0; i < RAND_BEATS; i++) begin
			if (i >= RAND_BEATS - CALM_TAIL) begin
				calm = 1'b1;
			end
			pick = $urandom_range(0, 9);
			m    = msg_port_t'($urandom);
			rx   = cw_port_t'($urandom);
			if (pick < 4) begin
				op = FUNC_ENCODE;
			end else begin
				op = FUNC_DECODE;
				if (pick < 9) begin
					rx = cw_port_t'(codebook_word($urandom_range(0, 2 * NBITS - 1)));
					repeat ($urandom_range(0, 3)) begin
						rx[$urandom_range(0, CW_W - 1)] ^= 1'b1;
					end
				end
			end
			send_beat(op, m, rx, 1'b0, no_result);
			sender_pause();
		end
		in_valid <= 1'b0;

		// Drain, then give stray results a chance to show up.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb_biorthogonal_code_codec_unit: done, clean");
		end else begin
			$display("tb_biorthogonal_code_codec_unit: done, errors");
		end
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off to back the pipeline up, none at the end.
	initial begin : receiver
		bit hold;
		int span;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			holding = 1'b0;
			if (calm) begin
				hold = 1'b0;
				span = 1;
			end else if (!held_long && beats_in >= HOLD_AFTER) begin
				hold      = 1'b1;
				span      = LONG_HOLD;
				held_long = 1'b1;
				holding   = 1'b1;
			end else begin
				hold = ($urandom_range(0, 2) == 0);
				span = $urandom_range(1, 12);
			end
			out_stall <= hold;
			repeat (span) @(posedge clk);
		end
	end

	// Record accepted beats, compare accepted results in order, and watch for a hang.
	always @(posedge clk) begin : result_checker
		codec_result_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (in_valid && !in_stall) begin
				if (cur_typed) begin
					pending_results.push_back(cur_typed_result);
				end else begin
					pending_results.push_back(codec_outcome(func_t'(func), message_in,
						received_word));
				end
				beats_in++;
				quiet_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (pending_results.size() == 0) begin
					$error("unexpected result: codeword_out=%h message_out=%h",
						codeword_out, message_out);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (codeword_out !== want.cw) begin
						$error("codeword_out: expected %h, actual %h", want.cw, codeword_out);
						errors++;
					end
					if (message_out !== want.msg) begin
						$error("message_out: expected %h, actual %h", want.msg, message_out);
						errors++;
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_biorthogonal_code_codec_unit: done, errors");
				$finish;
			end
		end
	end

endmodule
